### hdl/nrmc_pkg.sv
// nrmc_pkg: shared types and character constants for the rmc sentence parser
// no dependencies
`timescale 1ns / 1ps
package nrmc_pkg;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [23:0] ACC_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_line;
    } t_in;

    typedef struct packed {
        logic [39:0] header_text;
        logic [27:0] utc_time;
        logic [7:0]  fix_status;
        logic [35:0] latitude;
        logic [38:0] longitude;
        logic [23:0] ground_speed;
        logic [20:0] utc_date;
        logic [15:0] checksum_text;
    } t_out;
endpackage

### hdl/nrmc_if.sv
// nrmc_if: valid/ready channel carrying one payload
// no dependencies; the payload type is a parameter
`timescale 1ns / 1ps
interface nrmc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/nmea_rmc_sentence_parser_top.sv
// nmea_rmc_sentence_parser_top: rmc parser with input channel and result register
// depends on nrmc_pkg, nrmc_if, nrmc_core
//  channel | dir | payload
//  s_in    | in  | rx_byte, end_of_line
//  m_out   | out | header_text .. checksum_text
// one byte per cycle unless stalled; result valid the cycle after the final byte
// reset (i_rst_n low, synchronous) clears parse state and kept values
// input stalls only while a finished result waits and is not taken
`timescale 1ns / 1ps
module nmea_rmc_sentence_parser_top #(
    parameter int HEADER_CHARS = 5,
    parameter int SECOND_CHARS = 5,
    parameter int LAT_FRACTION_DIGITS = 4,
    parameter int LON_FRACTION_DIGITS = 4,
    parameter int SPEED_FRACTION_DIGITS = 3,
    parameter int CHECKSUM_CHARS = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    nrmc_if.sink   s_in,
    nrmc_if.source m_out
);
    logic           r_valid;
    nrmc_pkg::t_out r_data;
    logic           en, last;
    nrmc_pkg::t_out kept;

    assign s_in.ready = !r_valid || m_out.ready;
    assign en = s_in.valid && s_in.ready;

    nrmc_core #(
        .HEADER_CHARS(HEADER_CHARS), .SECOND_CHARS(SECOND_CHARS),
        .LAT_FRACTION_DIGITS(LAT_FRACTION_DIGITS),
        .LON_FRACTION_DIGITS(LON_FRACTION_DIGITS),
        .SPEED_FRACTION_DIGITS(SPEED_FRACTION_DIGITS),
        .CHECKSUM_CHARS(CHECKSUM_CHARS)
    ) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_in(s_in.data),
        .o_last(last), .o_kept(kept)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_in.ready) begin
            r_valid <= en && last;
        end
        if (en && last) r_data <= kept;
    end

    assign m_out.valid = r_valid;
    assign m_out.data = r_data;
endmodule

### hdl/nrmc_digit.sv
// nrmc_digit: one character step of a numeric subfield accumulator
// depends on nrmc_pkg
`timescale 1ns / 1ps
module nrmc_digit (
    input  logic [7:0]  i_c,
    input  logic [1:0]  i_frac,
    input  logic        i_start,
    input  logic [23:0] i_acc,
    input  logic        i_stop,
    input  logic [2:0]  i_pts,
    output logic [23:0] o_acc,
    output logic        o_stop,
    output logic [2:0]  o_pts,
    output logic [33:0] o_val
);
    logic [23:0] acc;
    logic        stp;
    logic [2:0]  pts;
    logic [27:0] prod;
    logic [1:0]  taken;
    logic [33:0] v;
    always_comb begin
        acc = i_start ? 24'd0 : i_acc;
        stp = i_start ? 1'b0 : i_stop;
        pts = i_start ? 3'd0 : i_pts;
        prod = {4'd0, acc} * 28'd10 + {20'd0, i_c - nrmc_pkg::CH_ZERO};
        o_acc = acc;
        o_stop = stp;
        o_pts = pts;
        if (!stp) begin
            if (i_c >= nrmc_pkg::CH_ZERO && i_c <= nrmc_pkg::CH_NINE) begin
                if (pts == 3'd0 || (pts - 3'd1) < {1'b0, i_frac}) begin
                    o_acc = (prod > {4'd0, nrmc_pkg::ACC_MAX}) ? nrmc_pkg::ACC_MAX
                                                               : prod[23:0];
                    if (pts != 3'd0) o_pts = pts + 3'd1;
                end
            end else if (i_c == nrmc_pkg::CH_POINT && pts == 3'd0) begin
                o_pts = 3'd1;
            end else begin
                o_stop = 1'b1;
            end
        end
        taken = (o_pts == 3'd0) ? 2'd0 : o_pts[1:0] - 2'd1;
        v = {10'd0, o_acc};
        if (o_pts != 3'd0 && o_pts - 3'd1 >= {1'b0, i_frac}) taken = i_frac;
        case (i_frac - taken)
            2'd1: v = {10'd0, o_acc} * 34'd10;
            2'd2: v = {10'd0, o_acc} * 34'd100;
            2'd3: v = {10'd0, o_acc} * 34'd1000;
            default: v = {10'd0, o_acc};
        endcase
    end

    assign o_val = v;
endmodule

### hdl/nrmc_core.sv
// nrmc_core: field/char tracking and kept values, one byte per enabled cycle
// depends on nrmc_pkg and nrmc_digit
`timescale 1ns / 1ps
module nrmc_core #(
    parameter int HEADER_CHARS = 5,
    parameter int SECOND_CHARS = 5,
    parameter int LAT_FRACTION_DIGITS = 4,
    parameter int LON_FRACTION_DIGITS = 4,
    parameter int SPEED_FRACTION_DIGITS = 3,
    parameter int CHECKSUM_CHARS = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  nrmc_pkg::t_in i_in,
    output logic          o_last,
    output nrmc_pkg::t_out o_kept
);
    logic [3:0]  r_f, n_f;
    logic [4:0]  r_p, n_p;
    logic [23:0] r_acc, n_acc;
    logic        r_stop, n_stop;
    logic [2:0]  r_pts, n_pts;
    nrmc_pkg::t_out r_k, n_k;

    logic [7:0]  c;
    logic        last, ok, sub, start;
    logic [1:0]  frac;
    logic [23:0] d_acc;
    logic        d_stop;
    logic [2:0]  d_pts;
    logic [33:0] v;
    logic [4:0]  p_lo;

    assign c = i_in.rx_byte;
    assign last = i_in.end_of_line || (c == nrmc_pkg::CH_NUL);

    // subfield decode for the current field and position
    always_comb begin
        sub = 1'b0;
        p_lo = 5'd0;
        frac = 2'd0;
        case (r_f)
            4'd2: begin
                sub = 1'b1;
                if (r_p < 5'd2) p_lo = 5'd0;
                else if (r_p < 5'd4) p_lo = 5'd2;
                else begin
                    p_lo = 5'd4; frac = 2'd2;
                    sub = r_p < 5'(4 + SECOND_CHARS);
                end
            end
            4'd4: begin
                sub = 1'b1;
                if (r_p < 5'd2) p_lo = 5'd0;
                else if (r_p < 5'd4) p_lo = 5'd2;
                else if (r_p == 5'd4) sub = 1'b0;
                else begin
                    p_lo = 5'd5;
                    sub = r_p < 5'(5 + LAT_FRACTION_DIGITS);
                end
            end
            4'd6: begin
                sub = 1'b1;
                if (r_p < 5'd3) p_lo = 5'd0;
                else if (r_p < 5'd5) p_lo = 5'd3;
                else if (r_p == 5'd5) sub = 1'b0;
                else begin
                    p_lo = 5'd6;
                    sub = r_p < 5'(6 + LON_FRACTION_DIGITS);
                end
            end
            4'd8: begin
                sub = 1'b1; p_lo = 5'd0; frac = 2'(SPEED_FRACTION_DIGITS);
            end
            4'd10: begin
                sub = 1'b1;
                if (r_p < 5'd2) p_lo = 5'd0;
                else if (r_p < 5'd4) p_lo = 5'd2;
                else if (r_p < 5'd6) p_lo = 5'd4;
                else sub = 1'b0;
            end
            default: sub = 1'b0;
        endcase
        start = (r_p == p_lo);
    end

    nrmc_digit u_digit (
        .i_c(c), .i_frac(frac), .i_start(start), .i_acc(r_acc), .i_stop(r_stop),
        .i_pts(r_pts), .o_acc(d_acc), .o_stop(d_stop), .o_pts(d_pts), .o_val(v)
    );

    function automatic logic [13:0] sat(input logic [33:0] x, input int w);
        logic [33:0] m;
        m = (34'd1 << w) - 34'd1;
        return (x > m) ? m[13:0] : x[13:0];
    endfunction

    always_comb begin
        n_f = r_f; n_p = r_p; n_acc = r_acc; n_stop = r_stop; n_pts = r_pts;
        n_k = r_k;
        ok = (r_k.fix_status == nrmc_pkg::CH_A);
        if (r_p == 5'd0) begin
            case (r_f)
                4'd1: n_k.header_text = '0;
                4'd2: n_k.utc_time = '0;
                4'd3: n_k.fix_status = '0;
                4'd4: if (ok) n_k.latitude[35:8] = '0;
                4'd5: if (ok) n_k.latitude[7:0] = '0;
                4'd6: if (ok) n_k.longitude[38:8] = '0;
                4'd7: if (ok) n_k.longitude[7:0] = '0;
                4'd8: n_k.ground_speed = '0;
                4'd10: n_k.utc_date = '0;
                4'd13: n_k.checksum_text = '0;
                default: n_k = n_k;
            endcase
        end
        if (c == nrmc_pkg::CH_COMMA || last) begin
            n_f = (r_f < 4'd15) ? r_f + 4'd1 : 4'd15;
            n_p = 5'd0;
        end else begin
            n_p = (r_p < 5'd31) ? r_p + 5'd1 : 5'd31;
            if (r_f == 4'd1 && r_p >= 5'd1 && r_p <= 5'(HEADER_CHARS))
                n_k.header_text[8 * (5 - r_p[2:0]) +: 8] = c;
            if (r_f == 4'd3 && r_p == 5'd0) n_k.fix_status = c;
            if (r_f == 4'd5 && ok && r_p == 5'd0) n_k.latitude[7:0] = c;
            if (r_f == 4'd7 && ok && r_p == 5'd0) n_k.longitude[7:0] = c;
            if (r_f == 4'd13 && r_p >= 5'd2 && r_p < 5'(2 + CHECKSUM_CHARS))
                n_k.checksum_text[8 * (3 - r_p[1:0]) +: 8] = c;
            if (sub && !((r_f == 4'd4 || r_f == 4'd6) && !ok)) begin
                n_acc = d_acc; n_stop = d_stop; n_pts = d_pts;
                case (r_f)
                    4'd2: begin
                        if (p_lo == 5'd0) n_k.utc_time[27:21] = 7'(sat(v, 7));
                        else if (p_lo == 5'd2) n_k.utc_time[20:14] = 7'(sat(v, 7));
                        else n_k.utc_time[13:0] = sat(v, 14);
                    end
                    4'd4: begin
                        if (p_lo == 5'd0) n_k.latitude[35:29] = 7'(sat(v, 7));
                        else if (p_lo == 5'd2) n_k.latitude[28:22] = 7'(sat(v, 7));
                        else n_k.latitude[21:8] = sat(v, 14);
                    end
                    4'd6: begin
                        if (p_lo == 5'd0) n_k.longitude[38:29] = 10'(sat(v, 10));
                        else if (p_lo == 5'd3) n_k.longitude[28:22] = 7'(sat(v, 7));
                        else n_k.longitude[21:8] = sat(v, 14);
                    end
                    4'd8: n_k.ground_speed = (v > 34'hFFFFFF) ? 24'hFFFFFF : v[23:0];
                    4'd10: begin
                        if (p_lo == 5'd0) n_k.utc_date[20:14] = 7'(sat(v, 7));
                        else if (p_lo == 5'd2) n_k.utc_date[13:7] = 7'(sat(v, 7));
                        else n_k.utc_date[6:0] = 7'(sat(v, 7));
                    end
                    default: n_acc = n_acc;
                endcase
            end
        end
        if (last) begin
            n_f = 4'd1; n_p = 5'd0; n_acc = '0; n_stop = 1'b0; n_pts = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f <= 4'd1; r_p <= '0; r_acc <= '0; r_stop <= 1'b0; r_pts <= '0;
            r_k <= '0;
        end else if (i_en) begin
            r_f <= n_f; r_p <= n_p; r_acc <= n_acc; r_stop <= n_stop;
            r_pts <= n_pts; r_k <= n_k;
        end
    end

    assign o_last = last;
    assign o_kept = n_k;
endmodule
